@@ hdl/spq_pkg.sv @@
// spq_pkg: shared types and constants for the sorted priority queue
// no dependencies; used by the interfaces, controller, datapath and top level
package spq_pkg;

  localparam int unsigned Capacity = 16;
  localparam int unsigned CntW     = $clog2(Capacity + 1);
  localparam int unsigned ValW     = 32;
  localparam int unsigned PrioW    = 16;
  localparam int unsigned StatW    = 2;
  localparam int unsigned OccW     = 5;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_DELETE = 1'b1
  } action_e;

  typedef enum logic [StatW-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  typedef enum logic {
    CTL_IDLE = 1'b0,
    CTL_HOLD = 1'b1
  } ctl_state_e;

  typedef struct packed {
    logic signed [ValW-1:0]  value;
    logic signed [PrioW-1:0] prio;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic    do_insert;
    logic    do_delete;
    logic    load_out;
    status_e status;
  } spq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;
    logic full;
  } spq_stat_t;

endpackage

@@ hdl/spq_in_if.sv @@
// spq_in_if: request channel of the priority queue (valid/ready plus payload)
// depends on spq_pkg for field widths
interface spq_in_if;
  logic                                valid;
  logic                                ready;
  logic                                action;
  logic signed [spq_pkg::ValW-1:0]     value;
  logic signed [spq_pkg::PrioW-1:0]    priority_req;

  modport source (output valid, action, value, priority_req, input ready);
  modport sink   (input valid, action, value, priority_req, output ready);
endinterface

@@ hdl/spq_out_if.sv @@
// spq_out_if: result channel of the priority queue (valid/ready plus payload)
// depends on spq_pkg for field widths
interface spq_out_if;
  logic                                valid;
  logic                                ready;
  logic [spq_pkg::StatW-1:0]           status;
  logic signed [spq_pkg::ValW-1:0]     out_value;
  logic signed [spq_pkg::PrioW-1:0]    out_priority;
  logic [spq_pkg::OccW-1:0]            occupancy;

  modport source (output valid, status, out_value, out_priority, occupancy, input ready);
  modport sink   (input valid, status, out_value, out_priority, occupancy, output ready);
endinterface

@@ hdl/sorted_priority_queue_top.sv @@
// sorted_priority_queue_top: bounded priority queue kept as a sorted register chain
// the result is valid in the cycle after the request transaction is accepted
// throughput: one transaction per cycle while results are taken; insert compares all entries at once
// reset: entry count cleared to zero, queue empty at once, no clearing pass
// depends on spq_pkg, spq_in_if, spq_out_if, spq_ctrl, spq_datapath
module sorted_priority_queue_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  spq_in_if.sink     in_i,
  spq_out_if.source  out_o
);

  spq_pkg::spq_cmd_t  cmd;
  spq_pkg::spq_stat_t stat;

  spq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_action_i (in_i.action),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  spq_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .value_i        (in_i.value),
    .prio_i         (in_i.priority_req),
    .status_o       (out_o.status),
    .out_value_o    (out_o.out_value),
    .out_priority_o (out_o.out_priority),
    .occupancy_o    (out_o.occupancy)
  );

endmodule

@@ hdl/spq_ctrl.sv @@
// spq_ctrl: handshake controller, decodes each transaction into datapath commands
// depends on spq_pkg
module spq_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                in_action_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  spq_pkg::spq_stat_t  stat_i,
  output spq_pkg::spq_cmd_t   cmd_o
);

  spq_pkg::ctl_state_e state_q, state_d;
  logic accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= spq_pkg::CTL_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    in_ready_o  = (state_q == spq_pkg::CTL_IDLE) || out_ready_i;
    out_valid_o = (state_q == spq_pkg::CTL_HOLD);
    accept      = in_valid_i && in_ready_o;
    state_d     = state_q;
    cmd_o       = '0;
    cmd_o.status = spq_pkg::STAT_OK;

    unique case (state_q)
      spq_pkg::CTL_IDLE: begin
        if (accept) state_d = spq_pkg::CTL_HOLD;
      end
      spq_pkg::CTL_HOLD: begin
        if (out_ready_i && !accept) state_d = spq_pkg::CTL_IDLE;
      end
      default: state_d = spq_pkg::CTL_IDLE;
    endcase

    if (accept) begin
      cmd_o.load_out = 1'b1;
      if (in_action_i == spq_pkg::ACT_INSERT) begin
        if (stat_i.full) cmd_o.status = spq_pkg::STAT_FULL;
        else cmd_o.do_insert = 1'b1;
      end else begin
        if (stat_i.empty) cmd_o.status = spq_pkg::STAT_EMPTY;
        else cmd_o.do_delete = 1'b1;
      end
    end
  end

`ifndef SYNTH
  a_no_double_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.do_insert && cmd_o.do_delete))
    else $error("insert and delete issued together");
  a_op_needs_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.do_insert || cmd_o.do_delete) |-> cmd_o.load_out)
    else $error("queue update without result load");
  a_load_gives_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |=> out_valid_o)
    else $error("result not presented after transaction");
`endif

endmodule

@@ hdl/spq_datapath.sv @@
// spq_datapath: sorted entry chain, entry count and result register
// depends on spq_pkg; driven by commands from spq_ctrl
module spq_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  spq_pkg::spq_cmd_t                   cmd_i,
  output spq_pkg::spq_stat_t                  stat_o,
  input  logic signed [spq_pkg::ValW-1:0]     value_i,
  input  logic signed [spq_pkg::PrioW-1:0]    prio_i,
  output logic [spq_pkg::StatW-1:0]           status_o,
  output logic signed [spq_pkg::ValW-1:0]     out_value_o,
  output logic signed [spq_pkg::PrioW-1:0]    out_priority_o,
  output logic [spq_pkg::OccW-1:0]            occupancy_o
);

  spq_pkg::entry_t                    entry_q [spq_pkg::Capacity];
  spq_pkg::entry_t                    entry_d [spq_pkg::Capacity];
  logic [spq_pkg::CntW-1:0]           count_q, count_d;
  logic [spq_pkg::Capacity-1:0]       le;
  logic [spq_pkg::StatW-1:0]          status_q;
  logic signed [spq_pkg::ValW-1:0]    oval_q;
  logic signed [spq_pkg::PrioW-1:0]   oprio_q;
  logic [spq_pkg::OccW-1:0]           occ_q;
  spq_pkg::entry_t                    new_entry;

  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == spq_pkg::CntW'(spq_pkg::Capacity));
  assign new_entry.value = value_i;
  assign new_entry.prio  = prio_i;

  // held entries that stay ahead of the new one form a prefix
  always_comb begin
    for (int i = 0; i < spq_pkg::Capacity; i++) begin
      le[i] = (spq_pkg::CntW'(i) < count_q) && (entry_q[i].prio <= prio_i);
    end
  end

  always_comb begin
    count_d = count_q;
    for (int i = 0; i < spq_pkg::Capacity; i++) begin
      entry_d[i] = entry_q[i];
    end
    if (cmd_i.do_insert) begin
      count_d = count_q + 1'b1;
      if (!le[0]) entry_d[0] = new_entry;
      for (int i = 1; i < spq_pkg::Capacity; i++) begin
        if (!le[i]) begin
          if (le[i-1]) entry_d[i] = new_entry;
          else entry_d[i] = entry_q[i-1];
        end
      end
    end else if (cmd_i.do_delete) begin
      count_d = count_q - 1'b1;
      for (int i = 0; i < spq_pkg::Capacity - 1; i++) begin
        entry_d[i] = entry_q[i+1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < spq_pkg::Capacity; i++) begin
      entry_q[i] <= entry_d[i];
    end
    if (cmd_i.load_out) begin
      status_q <= cmd_i.status;
      oval_q   <= cmd_i.do_delete ? entry_q[0].value : '0;
      oprio_q  <= cmd_i.do_delete ? entry_q[0].prio : '0;
      occ_q    <= spq_pkg::OccW'(count_d);
    end
  end

  assign status_o       = status_q;
  assign out_value_o    = oval_q;
  assign out_priority_o = oprio_q;
  assign occupancy_o    = occ_q;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= spq_pkg::CntW'(spq_pkg::Capacity))
    else $error("entry count above capacity");
  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.do_insert |=> count_q == $past(count_q) + 1'b1)
    else $error("insert did not grow the queue");
  a_head_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q > spq_pkg::CntW'(1)) |-> entry_q[0].prio <= entry_q[1].prio)
    else $error("head entries out of order");
`endif

endmodule
